[hw/rtl/sle_pkg.sv]
package sle_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);

	localparam int FUNC_W   = 3;
	localparam int POS_W    = 5;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	localparam logic [FUNC_W-1:0] FN_INSERT = 3'd0;
	localparam logic [FUNC_W-1:0] FN_DELETE = 3'd1;
	localparam logic [FUNC_W-1:0] FN_UPDATE = 3'd2;
	localparam logic [FUNC_W-1:0] FN_GET    = 3'd3;
	localparam logic [FUNC_W-1:0] FN_LOCATE = 3'd4;
	localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BADPOS   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

	localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);

endpackage

[hw/rtl/sequential_list_engine.sv]
// Ordered list of up to CAPACITY signed 32-bit values, addressed by 1-based
// position. One request on the input channel (func, position, value) gives
// exactly one result on the output channel (status, read_value,
// found_position, count). Both channels are valid/ready.
//
// Update, clear, rejected requests and unknown func go straight to the
// output stage; get reads the entry; delete shifts the entries behind the
// position down; insert shifts them up, or writes directly when appending;
// locate scans from the head until a hit or the last filled entry.
// The list lives in a single-write, single-read memory with registered read
// data; shifts and searches step through it one entry per cycle, so the
// more entries to move or scan, the longer the request. One request is
// in flight at a time: in_ready is high only while the sequencer is idle.
//
// Reset empties the list (count 0); entry contents are not cleared.
// A finished result sits in the output register until taken; while the
// receiver stalls, the next result waits in the sequencer and in_ready
// stays low.
module sequential_list_engine (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [sle_pkg::FUNC_W-1:0]     func,
	input  logic [sle_pkg::POS_W-1:0]      position,
	input  logic signed [sle_pkg::DATA_W-1:0] value,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [sle_pkg::STATUS_W-1:0]   status,
	output logic signed [sle_pkg::DATA_W-1:0] read_value,
	output logic [sle_pkg::POS_W-1:0]      found_position,
	output logic [sle_pkg::COUNT_W-1:0]    count
);
	import sle_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT_UP,
		S_INS_PUT,
		S_DEL_READ,
		S_SHIFT_DN,
		S_GET_READ,
		S_SCAN,
		S_OUT
	} state_t;

	state_t                state_q;
	logic [COUNT_W-1:0]    fill_q;
	logic [IDX_W-1:0]      ptr_q;
	logic [IDX_W-1:0]      pos_idx_q;
	logic [DATA_W-1:0]     val_q;
	logic [STATUS_W-1:0]   res_status_q;
	logic [DATA_W-1:0]     res_rd_q;
	logic [POS_W-1:0]      res_found_q;
	logic                  out_valid_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic [DATA_W-1:0]     out_rd_q;
	logic [POS_W-1:0]      out_found_q;
	logic [COUNT_W-1:0]    out_count_q;

	// list storage
	logic [DATA_W-1:0]     entries_q [CAPACITY];
	logic [DATA_W-1:0]     rdata_q;
	logic                  mem_we;
	logic [IDX_W-1:0]      mem_wa;
	logic [DATA_W-1:0]     mem_wd;
	logic [IDX_W-1:0]      mem_ra;

	logic                  pos_zero;
	logic                  ins_pos_ok;
	logic                  acc_pos_ok;
	logic [IDX_W-1:0]      pos_in_idx;
	logic [COUNT_W-1:0]    fill_plus1;
	logic [STATUS_W-1:0]   req_status;
	state_t                req_state;

	assign fill_plus1 = fill_q + COUNT_W'(1);
	assign pos_zero   = (position == '0);
	assign ins_pos_ok = !pos_zero && (COUNT_W'(position) <= fill_plus1);
	assign acc_pos_ok = !pos_zero && (COUNT_W'(position) <= fill_q);
	assign pos_in_idx = IDX_W'(position - POS_W'(1));

	assign in_ready       = (state_q == S_IDLE);
	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign read_value     = out_rd_q;
	assign found_position = out_found_q;
	assign count          = out_count_q;

	// request decode: early status and first sequencer state
	always_comb begin
		req_status = ST_OK;
		req_state  = S_OUT;
		case (func)
			FN_INSERT: begin
				if (!ins_pos_ok) begin
					req_status = ST_BADPOS;
				end else if (fill_q >= CAP_COUNT) begin
					req_status = ST_FULL;
				end else if (COUNT_W'(position) == fill_plus1) begin
					req_state = S_INS_PUT;
				end else begin
					req_state = S_SHIFT_UP;
				end
			end
			FN_DELETE: begin
				if (!acc_pos_ok) begin
					req_status = ST_BADPOS;
				end else begin
					req_state = S_DEL_READ;
				end
			end
			FN_UPDATE: begin
				if (!acc_pos_ok) begin
					req_status = ST_BADPOS;
				end
			end
			FN_GET: begin
				if (!acc_pos_ok) begin
					req_status = ST_BADPOS;
				end else begin
					req_state = S_GET_READ;
				end
			end
			FN_LOCATE: begin
				if (fill_q == '0) begin
					req_status = ST_NOTFOUND;
				end else begin
					req_state = S_SCAN;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = pos_idx_q;
		mem_wd = val_q;
		mem_ra = '0;
		unique case (state_q)
			S_IDLE: begin
				case (func) inside
					FN_INSERT: mem_ra = IDX_W'(fill_q - COUNT_W'(1));
					FN_DELETE, FN_GET: mem_ra = pos_in_idx;
					FN_UPDATE: begin
						mem_we = in_valid && acc_pos_ok;
						mem_wa = pos_in_idx;
						mem_wd = value;
					end
					default: mem_ra = '0;
				endcase
			end
			S_SHIFT_UP: begin
				// move entry ptr up by one, fetch the one below
				mem_we = 1'b1;
				mem_wa = ptr_q + IDX_W'(1);
				mem_wd = rdata_q;
				mem_ra = ptr_q - IDX_W'(1);
			end
			S_INS_PUT: mem_we = 1'b1;
			S_DEL_READ: mem_ra = pos_idx_q + IDX_W'(1);
			S_SHIFT_DN: begin
				mem_we = 1'b1;
				mem_wa = ptr_q - IDX_W'(1);
				mem_wd = rdata_q;
				mem_ra = ptr_q + IDX_W'(1);
			end
			S_SCAN: mem_ra = ptr_q + IDX_W'(1);
			default: mem_ra = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			entries_q[mem_wa] <= mem_wd;
		end
		rdata_q <= entries_q[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fill_q       <= '0;
			ptr_q        <= '0;
			pos_idx_q    <= '0;
			val_q        <= '0;
			res_status_q <= ST_OK;
			res_rd_q     <= '0;
			res_found_q  <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_OK;
			out_rd_q     <= '0;
			out_found_q  <= '0;
			out_count_q  <= '0;
		end else begin
			// S_OUT reloads the output register itself
			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						val_q        <= value;
						pos_idx_q    <= pos_in_idx;
						res_status_q <= req_status;
						res_rd_q     <= '0;
						res_found_q  <= '0;
						state_q      <= req_state;
						ptr_q        <= (func == FN_LOCATE) ? '0 :
							IDX_W'(fill_q - COUNT_W'(1));
						if (func == FN_CLEAR) begin
							fill_q <= '0;
						end
					end
				end
				S_SHIFT_UP: begin
					if (ptr_q == pos_idx_q) begin
						state_q <= S_INS_PUT;
					end else begin
						ptr_q <= ptr_q - IDX_W'(1);
					end
				end
				S_INS_PUT: begin
					fill_q  <= fill_plus1;
					state_q <= S_OUT;
				end
				S_DEL_READ: begin
					res_rd_q <= rdata_q;
					if (COUNT_W'(pos_idx_q) + COUNT_W'(1) == fill_q) begin
						fill_q  <= fill_q - COUNT_W'(1);
						state_q <= S_OUT;
					end else begin
						ptr_q   <= pos_idx_q + IDX_W'(1);
						state_q <= S_SHIFT_DN;
					end
				end
				S_SHIFT_DN: begin
					if (COUNT_W'(ptr_q) + COUNT_W'(1) == fill_q) begin
						fill_q  <= fill_q - COUNT_W'(1);
						state_q <= S_OUT;
					end else begin
						ptr_q <= ptr_q + IDX_W'(1);
					end
				end
				S_GET_READ: begin
					res_rd_q <= rdata_q;
					state_q  <= S_OUT;
				end
				S_SCAN: begin
					if (rdata_q == val_q) begin
						res_found_q <= POS_W'(ptr_q) + POS_W'(1);
						state_q     <= S_OUT;
					end else if (COUNT_W'(ptr_q) + COUNT_W'(1) == fill_q) begin
						res_status_q <= ST_NOTFOUND;
						state_q      <= S_OUT;
					end else begin
						ptr_q <= ptr_q + IDX_W'(1);
					end
				end
				S_OUT: begin
					// wait for a free output register
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_rd_q     <= res_rd_q;
						out_found_q  <= res_found_q;
						out_count_q  <= fill_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[hw/rtl/sle_checker.sv]
module sle_assert (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [sle_pkg::STATUS_W-1:0]   status,
	input  logic signed [sle_pkg::DATA_W-1:0] read_value,
	input  logic [sle_pkg::POS_W-1:0]      found_position,
	input  logic [sle_pkg::COUNT_W-1:0]    count
);
	import sle_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(read_value)
			&& $stable(found_position) && $stable(count))
		else $error("result changed while stalled");

	// one request in flight: no transfer right after a transfer
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> count <= CAP_COUNT)
		else $error("count above capacity");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> count == CAP_COUNT)
		else $error("full status on a list that is not full");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> read_value == '0 && found_position == '0)
		else $error("error result carries data");

endmodule

bind sequential_list_engine sle_assert u_sle_assert (.*);

[bench/sle_checker.sv]
module sle_checker
	import sle_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [FUNC_W-1:0]   func,
	input  logic [POS_W-1:0]    position,
	input  logic [DATA_W-1:0]   value,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [STATUS_W-1:0] status,
	input  logic [DATA_W-1:0]   read_value,
	input  logic [POS_W-1:0]    found_position,
	input  logic [COUNT_W-1:0]  count,
	output int                  errors,
	output int                  in_flight
);

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [DATA_W-1:0]   rdata;
		logic [POS_W-1:0]    found;
		logic [COUNT_W-1:0]  fill;
	} list_result_t;

	logic [DATA_W-1:0] list_mem [CAPACITY];
	int                list_fill;
	list_result_t      pending_results [$];

	task automatic report_mismatch(input string what);
		$display("mismatch @%0t: %s", $time, what);
		errors++;
	endtask

	// Applies one request to the shadow list and returns what the block must answer.
	function automatic list_result_t list_op_result(input logic [FUNC_W-1:0] f,
			input logic [POS_W-1:0] p, input logic [DATA_W-1:0] v);
		list_result_t r;
		int pi;
		int i;
		r = '0;
		r.status = ST_OK;
		pi = int'(p);
		case (f)
			FN_INSERT: begin
				if (pi < 1 || pi > list_fill + 1) begin
					r.status = ST_BADPOS;
				end else if (list_fill >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					for (i = list_fill; i >= pi; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[pi-1] = v;
					list_fill++;
				end
			end
			FN_DELETE: begin
				if (pi < 1 || pi > list_fill) begin
					r.status = ST_BADPOS;
				end else begin
					r.rdata = list_mem[pi-1];
					for (i = pi; i < list_fill; i++)
						list_mem[i-1] = list_mem[i];
					list_fill--;
				end
			end
			FN_UPDATE: begin
				if (pi < 1 || pi > list_fill)
					r.status = ST_BADPOS;
				else
					list_mem[pi-1] = v;
			end
			FN_GET: begin
				if (pi < 1 || pi > list_fill)
					r.status = ST_BADPOS;
				else
					r.rdata = list_mem[pi-1];
			end
			FN_LOCATE: begin
				r.status = ST_NOTFOUND;
				for (i = 0; i < list_fill; i++) begin
					if (r.status == ST_NOTFOUND && list_mem[i] == v) begin
						r.found  = POS_W'(i + 1);
						r.status = ST_OK;
					end
				end
			end
			FN_CLEAR: begin
				list_fill = 0;
			end
			default: begin
			end
		endcase
		r.fill = COUNT_W'(list_fill);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_result_t want;
		if (!arst_n) begin
			list_fill = 0;
			errors = 0;
			pending_results.delete();
			in_flight <= 0;
		end else begin
			if (in_valid && in_ready)
				pending_results.push_back(list_op_result(func, position, value));
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result transfer with nothing pending");
				end else begin
					want = pending_results.pop_front();
					if (status !== want.status)
						report_mismatch($sformatf("status %0d, want %0d", status, want.status));
					if (read_value !== want.rdata)
						report_mismatch($sformatf("read_value %h, want %h",
							read_value, want.rdata));
					if (found_position !== want.found)
						report_mismatch($sformatf("found_position %0d, want %0d",
							found_position, want.found));
					if (count !== want.fill)
						report_mismatch($sformatf("count %0d, want %0d", count, want.fill));
				end
			end
			in_flight <= pending_results.size();
		end
	end

endmodule

[bench/testbench.sv]
module testbench;
	import sle_pkg::*;

	localparam logic [FUNC_W-1:0] FN_RSVD6 = 3'd6;
	localparam logic [FUNC_W-1:0] FN_RSVD7 = 3'd7;
	localparam int ITEMS_PER_PHASE = 330;
	localparam int DRAIN_LIMIT     = 5000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [FUNC_W-1:0]   func = FN_CLEAR;
	logic [POS_W-1:0]    position = '0;
	logic [DATA_W-1:0]   value = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [DATA_W-1:0]   read_value;
	logic [POS_W-1:0]    found_position;
	logic [COUNT_W-1:0]  count;

	int mismatch_count;
	int results_outstanding;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int est_fill = 0;

	sequential_list_engine dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .position(position), .value(value),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .read_value(read_value),
		.found_position(found_position), .count(count)
	);

	sle_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .position(position), .value(value),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .read_value(read_value),
		.found_position(found_position), .count(count),
		.errors(mismatch_count), .in_flight(results_outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

	// Returns at the edge where the request transfer happened.
	task automatic send_item(input logic [FUNC_W-1:0] f, input int p,
			input logic [DATA_W-1:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= f;
		position <= POS_W'(p);
		value    <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		// track fill only to aim positions
		case (f)
			FN_INSERT: if (p >= 1 && p <= est_fill + 1 && est_fill < CAPACITY) est_fill++;
			FN_DELETE: if (p >= 1 && p <= est_fill) est_fill--;
			FN_CLEAR:  est_fill = 0;
			default: begin
			end
		endcase
	endtask

	task automatic wait_for_results();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		do begin
			@(posedge clk);
			waited++;
		end while (results_outstanding != 0 && waited < DRAIN_LIMIT);
	endtask

	initial begin
		logic [FUNC_W-1:0] f;
		logic [DATA_W-1:0] v;
		int p;
		int r;
		int span;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 37;
		recv_idle_pct = 77;

		// empty list and bad positions
		send_item(FN_CLEAR, 0, 32'h0);
		send_item(FN_DELETE, 1, 32'h0);
		send_item(FN_INSERT, 0, 32'h5);
		send_item(FN_INSERT, 2, 32'h5);
		// fill to capacity, alternating head and tail inserts
		for (int k = 0; k < CAPACITY; k++) begin
			case (k)
				0: v = 32'h8000_0000;
				1: v = 32'h7fff_ffff;
				2: v = 32'h0;
				3: v = 32'hffff_ffff;
				default: v = $urandom;
			endcase
			send_item(FN_INSERT, (k % 2) ? 1 : k + 1, v);
		end
		send_item(FN_INSERT, CAPACITY + 1, 32'h1);
		send_item(FN_INSERT, 1, 32'h1);
		send_item(FN_LOCATE, 0, 32'h7fff_ffff);
		send_item(FN_LOCATE, 0, 32'h1234_5679);
		send_item(FN_UPDATE, CAPACITY, 32'hffff_ffff);
		send_item(FN_GET, 31, 32'h0);
		send_item(FN_DELETE, 1, 32'h0);
		send_item(FN_RSVD6, 31, 32'hffff_ffff);

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin send_idle_pct = 37; recv_idle_pct = 77; end
				1: begin send_idle_pct = 77; recv_idle_pct = 37; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			repeat (ITEMS_PER_PHASE) begin
				r = $urandom_range(99);
				if (r < 35)      f = FN_INSERT;
				else if (r < 57) f = FN_DELETE;
				else if (r < 69) f = FN_UPDATE;
				else if (r < 82) f = FN_GET;
				else if (r < 95) f = FN_LOCATE;
				else if (r < 98) f = FN_CLEAR;
				else             f = $urandom_range(1) ? FN_RSVD7 : FN_RSVD6;
				span = (f == FN_INSERT) ? est_fill + 1 : ((est_fill > 0) ? est_fill : 1);
				if ($urandom_range(9) == 0)
					p = $urandom_range(31);
				else
					p = $urandom_range(span, 1);
				// small values make locate hits common
				case ($urandom_range(3))
					0: v = $urandom_range(7);
					1: v = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
					default: v = $urandom;
				endcase
				send_item(f, p, v);
			end
			wait_for_results();
		end

		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && results_outstanding == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
